### hw/rtl/median_filter_3x3_rgb_unit_macros.svh
// ----------------------------------------------------------------------------
// median filter 3x3 rgb assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_RGB_UNIT_MACROS_SVH
`define MEDIAN_FILTER_3X3_RGB_UNIT_MACROS_SVH

// same-cycle implication
`define MF3_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// sizes, payload types and register codes of the 3x3 rgb median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

	// frame size limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MIN_SIZE   = 3;

	// counter and size widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WSZ_W = COL_W + 1;
	localparam int HSZ_W = ROW_W + 1;

	// field widths
	localparam int SIZE_W    = 12;
	localparam int CH_W      = 8;
	localparam int POS_W     = 11;
	localparam int CFG_IDX_W = 2;

	// window geometry
	localparam int WIN_DIM  = 3;
	localparam int WIN_TAPS = WIN_DIM * WIN_DIM;

	// register reset values
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

	typedef logic [CH_W-1:0] sample_t;

	typedef struct packed {
		sample_t pixel_red;
		sample_t pixel_green;
		sample_t pixel_blue;
	} pixel_t;

	typedef struct packed {
		sample_t          median_red;
		sample_t          median_green;
		sample_t          median_blue;
		logic [POS_W-1:0] out_column;
		logic [POS_W-1:0] out_row;
		logic             frame_last;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

endpackage

### hw/rtl/mf3_pixel_if.sv
// ----------------------------------------------------------------------------
// mf3_pixel_if
// valid/ready channel carrying one rgb pixel per transaction
// ----------------------------------------------------------------------------
interface mf3_pixel_if;
	import mf3_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/mf3_result_if.sv
// ----------------------------------------------------------------------------
// mf3_result_if
// valid/ready channel carrying one filtered pixel per transaction
// ----------------------------------------------------------------------------
interface mf3_result_if;
	import mf3_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/mf3_cfg_if.sv
// ----------------------------------------------------------------------------
// mf3_cfg_if
// register write channel: index and data per transaction
// ----------------------------------------------------------------------------
interface mf3_cfg_if;
	import mf3_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mf3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/median_filter_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_unit: streaming 3x3 per-channel median of rgb pixels
// throughput one pixel per cycle unless results.ready stalls the output;
// input, window, sort and output registers hold the pixel, the window load,
// the column sort with row reduction, and the final median of three
// reset clears counters, window and pipeline valids and sets the size registers
// to 640 by 480; the line stores are not cleared and take no clearing pass
`include "median_filter_3x3_rgb_unit_macros.svh"

module median_filter_3x3_rgb_unit (
	input logic          clk,
	input logic          arst_n,
	mf3_pixel_if.sink    pixels,
	mf3_result_if.source results,
	mf3_cfg_if.sink      cfg
);
	import mf3_pkg::*;

	typedef struct packed {
		sample_t lo_max;
		sample_t md_med;
		sample_t hi_min;
	} trio_t;

	typedef sample_t taps_t [WIN_TAPS];

	// small sorting helpers
	function automatic sample_t min2(input sample_t a, input sample_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic sample_t max2(input sample_t a, input sample_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// sort each window column, then reduce lows, middles and highs
	function automatic trio_t reduce9(input taps_t t);
		sample_t lo [WIN_DIM];
		sample_t md [WIN_DIM];
		sample_t hi [WIN_DIM];
		trio_t   r;
		for (int c = 0; c < WIN_DIM; c++) begin
			lo[c] = min2(min2(t[c], t[WIN_DIM + c]), t[2 * WIN_DIM + c]);
			md[c] = med3(t[c], t[WIN_DIM + c], t[2 * WIN_DIM + c]);
			hi[c] = max2(max2(t[c], t[WIN_DIM + c]), t[2 * WIN_DIM + c]);
		end
		r.lo_max = max2(max2(lo[0], lo[1]), lo[2]);
		r.md_med = med3(md[0], md[1], md[2]);
		r.hi_min = min2(min2(hi[0], hi[1]), hi[2]);
		return r;
	endfunction

	// configuration and position state
	logic [SIZE_W-1:0] width_q, height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WSZ_W-1:0]  w_eff;
	logic [HSZ_W-1:0]  h_eff;
	logic              cfg_hit;
	logic              col_end, row_end;

	// pipeline
	logic             valid_s1, valid_s2, valid_s3, out_valid_q;
	pixel_t           pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             prod_s1, last_s1, last_s2, last_s3;
	logic [POS_W-1:0] ocol_s1, orow_s1, ocol_s2, orow_s2, ocol_s3, orow_s3;
	pixel_t           win_s2 [WIN_TAPS];
	trio_t            red_s3, grn_s3, blu_s3;
	result_t          res_q;
	logic             acc, en2, en3, en4;

	// line store ports
	pixel_t up_rd, mid_rd;

	// window taps per channel
	taps_t red_taps, grn_taps, blu_taps;

	// assertion helpers
	logic pos_in_range;
	logic res_interior;
	logic pos_zero;

	// effective frame size, clamped to the supported range
	always_comb begin
		if (width_q < SIZE_W'(MIN_SIZE)) begin
			w_eff = WSZ_W'(MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WSZ_W'(MAX_WIDTH);
		end else begin
			w_eff = WSZ_W'(width_q);
		end
		if (height_q < SIZE_W'(MIN_SIZE)) begin
			h_eff = HSZ_W'(MIN_SIZE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HSZ_W'(MAX_HEIGHT);
		end else begin
			h_eff = HSZ_W'(height_q);
		end
	end

	assign col_end = ({1'b0, col_q} + WSZ_W'(1)) == w_eff;
	assign row_end = ({1'b0, row_q} + HSZ_W'(1)) == h_eff;

	// handshakes and stage enables
	assign en4            = valid_s3 && (!out_valid_q || results.ready);
	assign en3            = valid_s2 && (!valid_s3 || en4);
	assign en2            = valid_s1 && (!valid_s2 || en3);
	assign pixels.ready   = !valid_s1 || en2;
	assign acc            = pixels.valid && pixels.ready;
	assign cfg.ready      = 1'b1;
	assign cfg_hit        = cfg.valid && ((cfg.index == REG_IMAGE_WIDTH) ||
	                        (cfg.index == REG_IMAGE_HEIGHT));

	// size registers and raster position; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (acc) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (cfg.valid) begin
				case (cfg.index)
					REG_IMAGE_WIDTH:  width_q  <= cfg.data;
					REG_IMAGE_HEIGHT: height_q <= cfg.data;
					default: ;
				endcase
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// line stores: read at transaction, write back when stage 1 moves on
	mf3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_upper (
		.clk     (clk),
		.wr_en   (en2),
		.wr_addr (col_s1),
		.wr_data (mid_rd),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	mf3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_middle (
		.clk     (clk),
		.wr_en   (en2),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_en   (acc),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pixels.ready) begin
				valid_s1 <= pixels.valid;
			end
			if (en2) begin
				valid_s2 <= prod_s1;
			end else if (en3) begin
				valid_s2 <= 1'b0;
			end
			if (en3) begin
				valid_s3 <= 1'b1;
			end else if (en4) begin
				valid_s3 <= 1'b0;
			end
			if (en4) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1: pixel, position and result tags
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixels.data;
			col_s1  <= col_q;
			prod_s1 <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
			last_s1 <= col_end && row_end;
			ocol_s1 <= POS_W'(col_q - COL_W'(1));
			orow_s1 <= POS_W'(row_q - ROW_W'(1));
		end
	end

	// stage 2: window shift, newest column from line stores and input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_TAPS; i++) begin
				win_s2[i] <= '0;
			end
		end else if (en2) begin
			for (int r = 0; r < WIN_DIM; r++) begin
				win_s2[r * WIN_DIM]     <= win_s2[r * WIN_DIM + 1];
				win_s2[r * WIN_DIM + 1] <= win_s2[r * WIN_DIM + 2];
			end
			win_s2[WIN_DIM - 1]     <= up_rd;
			win_s2[2 * WIN_DIM - 1] <= mid_rd;
			win_s2[WIN_TAPS - 1]    <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
			last_s2 <= last_s1;
		end
	end

	// split window into channel taps
	always_comb begin
		for (int i = 0; i < WIN_TAPS; i++) begin
			red_taps[i] = win_s2[i].pixel_red;
			grn_taps[i] = win_s2[i].pixel_green;
			blu_taps[i] = win_s2[i].pixel_blue;
		end
	end

	// stage 3: column sort and row reduction per channel
	always_ff @(posedge clk) begin
		if (en3) begin
			red_s3  <= reduce9(red_taps);
			grn_s3  <= reduce9(grn_taps);
			blu_s3  <= reduce9(blu_taps);
			ocol_s3 <= ocol_s2;
			orow_s3 <= orow_s2;
			last_s3 <= last_s2;
		end
	end

	// output register: final median of three
	always_ff @(posedge clk) begin
		if (en4) begin
			res_q.median_red   <= med3(red_s3.lo_max, red_s3.md_med, red_s3.hi_min);
			res_q.median_green <= med3(grn_s3.lo_max, grn_s3.md_med, grn_s3.hi_min);
			res_q.median_blue  <= med3(blu_s3.lo_max, blu_s3.md_med, blu_s3.hi_min);
			res_q.out_column   <= ocol_s3;
			res_q.out_row      <= orow_s3;
			res_q.frame_last   <= last_s3;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = res_q;

	// assertions
	assign pos_in_range = ({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff);
	assign res_interior = (results.data.out_column != '0) && (results.data.out_row != '0);
	assign pos_zero     = (col_q == '0) && (row_q == '0);

	`MF3_ASSERT_IMP(a_store_no_collide, en2 && acc, col_s1 != col_q, "line store address collision")
	`MF3_ASSERT_IMP(a_pos_in_frame, 1'b1, pos_in_range, "raster position outside frame")
	`MF3_ASSERT_IMP(a_result_interior, results.valid, res_interior, "border pixel result")
	`MF3_ASSERT_NXT(a_cfg_restart, cfg_hit, pos_zero, "register write did not restart frame")

endmodule
